[hw/rtl/ffsa_pkg.sv]
// ============================================================================
// ffsa_pkg - shared definitions for the first-fit segment allocator
// Sizes, widths, status, operation and register codes, and the sequencer state type.
// ============================================================================
package ffsa_pkg;

    localparam int MAX_SEGMENTS = 32;
    localparam int HEADER_BYTES = 16;

    // table index, count (must hold MAX_SEGMENTS itself), span accumulator
    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int ACC_W = 34 + IDX_W;

    // table entry: {used, payload size}
    localparam int ENT_W = 33;

    // item layout on the stream ports
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 40;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_ROOM = 2'd1,
        STATUS_UNKNOWN = 2'd2,
        STATUS_NULL    = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        REG_HEAP_BASE  = 1'b0,
        REG_HEAP_BYTES = 1'b1
    } reg_idx_t;

    typedef enum logic [14:0] {
        ST_IDLE   = 15'h0001,
        ST_A_RD   = 15'h0002,
        ST_A_EV   = 15'h0004,
        ST_SH_RD  = 15'h0008,
        ST_SH_WR  = 15'h0010,
        ST_SPL_HI = 15'h0020,
        ST_SPL_LO = 15'h0040,
        ST_APPEND = 15'h0080,
        ST_ADDR   = 15'h0100,
        ST_F_RD   = 15'h0200,
        ST_F_EV   = 15'h0400,
        ST_M_RD   = 15'h0800,
        ST_M_EV   = 15'h1000,
        ST_M_LAST = 15'h2000,
        ST_DONE   = 15'h4000
    } state_t;

endpackage

[hw/rtl/ffsa_ram.sv]
// ============================================================================
// ffsa_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ============================================================================
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/first_fit_segment_allocator.sv]
// ============================================================================
// first_fit_segment_allocator - first-fit pool allocator with coalescing
// Address-ordered segment table in RAM, walked by a small sequencer.
// ============================================================================
// Usage:
//   Input items arrive on s_tvalid/s_tready. s_tuser carries the operation
//   (0 allocate, 1 free); s_tdata carries the request fields. Each item gives
//   exactly one result item on m_tvalid/m_tready: the granted payload address
//   (0 unless an allocate succeeded) and a status code.
//   heap_base and heap_bytes are set through cfg_we/cfg_addr/cfg_wdata while
//   the block is idle; writes take effect at the next clock edge.
// Sequencing:
//   One item at a time. The segment table sits in a single-port-read RAM, so
//   every table entry visited takes a read state and then an evaluate state.
//   Allocate walks the entries until one fits, shifts up the entries above
//   the split entry on a split, then writes the new entries and the result
//   address. Free walks to the match, then sweeps the whole table to merge.
//   An item that fails early (null free, rounded size too big, table full)
//   goes straight to the result state.
// Reset:
//   aresetn (synchronous, active low) empties the pool and restores the
//   register defaults (base 0, length 16 MiB). Table contents are not cleared;
//   only entries below the segment count are ever read.
// Stalls:
//   A result waits in the output register; the next item is taken meanwhile.
//   If a second result is ready while the first still waits, the sequencer
//   holds until m_tready frees the output register.
// ============================================================================
module first_fit_segment_allocator import ffsa_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,

    // configuration writes
    input  logic                cfg_we,
    input  logic [0:0]          cfg_addr,
    input  logic [31:0]         cfg_wdata,

    // request items
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,    // req_size[31:0], align[44:32], release_addr[76:45]
    input  logic [0:0]          s_tuser,    // op[0]

    // result items
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata     // result_addr[31:0], status[33:32]
);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [31:0]         base_reg, base_next;
    logic [31:0]         bytes_reg, bytes_next;
    logic [CNT_W-1:0]    count_reg, count_next;     // segments in the table
    logic [CNT_W-1:0]    idx_reg, idx_next;         // walk / shift pointer
    logic [CNT_W-1:0]    wp_reg, wp_next;           // merge write pointer
    logic [IDX_W-1:0]    hit_reg, hit_next;         // matched / split entry
    logic [ACC_W-1:0]    acc_reg, acc_next;         // span or running address
    logic [31:0]         size_reg, size_next;       // rounded request
    logic [32:0]         szh_reg, szh_next;         // rounded request + header
    logic [31:0]         hit_size_reg, hit_size_next;
    logic [31:0]         rel_reg, rel_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                pend_used_reg, pend_used_next;
    logic [31:0]         pend_size_reg, pend_size_next;
    logic [31:0]         res_addr_reg, res_addr_next;
    status_t             res_status_reg, res_status_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    // ------------------------------------------------------------------------
    // Input fields
    // ------------------------------------------------------------------------
    logic [31:0] in_req_size;
    logic [12:0] in_align;
    logic [31:0] in_release;
    op_t         in_op;

    assign in_req_size = s_tdata[31:0];
    assign in_align    = s_tdata[44:32];
    assign in_release  = s_tdata[76:45];
    assign in_op       = op_t'(s_tuser[0]);

    // size rounding: align 0 acts as 1
    logic [12:0] align_m1;
    logic [32:0] round_sum;
    logic [32:0] round_size;

    assign align_m1   = (in_align == 13'd0) ? 13'd0 : in_align - 13'd1;
    assign round_sum  = {1'b0, in_req_size} + {20'd0, align_m1};
    assign round_size = round_sum & ~{20'd0, align_m1};

    // ------------------------------------------------------------------------
    // Segment table
    // ------------------------------------------------------------------------
    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [ENT_W-1:0]  ram_wdata, ram_rdata;
    logic              rd_used;
    logic [31:0]       rd_size;

    ffsa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_used = ram_rdata[32];
    assign rd_size = ram_rdata[31:0];

    // ------------------------------------------------------------------------
    // Shared adder: a + b + header, operands picked by state
    // ------------------------------------------------------------------------
    logic [ACC_W-1:0] add_a, add_b, add_sum;

    always_comb begin
        add_a = acc_reg;
        add_b = {{(ACC_W-32){1'b0}}, rd_size};
        case (state_reg)
            ST_IDLE: begin
                add_a = {{(ACC_W-32){1'b0}}, base_reg};
                add_b = '0;
            end
            ST_APPEND: add_b = {{(ACC_W-32){1'b0}}, size_reg};
            ST_ADDR:   add_b = {{(ACC_W-32){1'b0}}, base_reg};
            ST_M_EV:   add_a = {{(ACC_W-32){1'b0}}, pend_size_reg};
            default:   add_a = acc_reg;
        endcase
    end

    assign add_sum = add_a + add_b + ACC_W'(HEADER_BYTES);

    // split fits only when strictly larger than request + header
    logic split_fit;
    assign split_fit = !rd_used && ({1'b0, szh_reg} < {2'b00, rd_size});

    // during the merge sweep the released entry reads as free
    logic merge_used;
    assign merge_used = rd_used && (idx_reg[IDX_W-1:0] != hit_reg);

    logic [CNT_W-1:0] hit_plus1;
    assign hit_plus1 = {{(CNT_W-IDX_W){1'b0}}, hit_reg} + CNT_W'(1);

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        base_next       = base_reg;
        bytes_next      = bytes_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        wp_next         = wp_reg;
        hit_next        = hit_reg;
        acc_next        = acc_reg;
        size_next       = size_reg;
        szh_next        = szh_reg;
        hit_size_next   = hit_size_reg;
        rel_next        = rel_reg;
        pend_valid_next = pend_valid_reg;
        pend_used_next  = pend_used_reg;
        pend_size_next  = pend_size_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;

        s_tready = (state_reg == ST_IDLE);

        if (cfg_we) begin
            case (reg_idx_t'(cfg_addr))
                REG_HEAP_BASE:  base_next  = cfg_wdata;
                REG_HEAP_BYTES: bytes_next = cfg_wdata;
                default:        base_next  = base_reg;
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    idx_next      = '0;
                    rel_next      = in_release;
                    res_addr_next = '0;
                    size_next     = round_size[31:0];
                    szh_next      = round_size + 33'(HEADER_BYTES);
                    if (in_op == OP_ALLOC) begin
                        acc_next = '0;
                        if (round_size[32] || count_reg >= CNT_W'(MAX_SEGMENTS)) begin
                            res_status_next = STATUS_NO_ROOM;
                            state_next      = ST_DONE;
                        end else begin
                            state_next = ST_A_RD;
                        end
                    end else begin
                        acc_next = add_sum;     // first payload address
                        if (in_release == 32'd0) begin
                            res_status_next = STATUS_NULL;
                            state_next      = ST_DONE;
                        end else begin
                            state_next = ST_F_RD;
                        end
                    end
                end
            end

            // ---- allocate: first-fit walk ----
            ST_A_RD: begin
                if (idx_reg == count_reg) begin
                    state_next = ST_APPEND;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_reg[IDX_W-1:0];
                    state_next = ST_A_EV;
                end
            end

            ST_A_EV: begin
                if (split_fit) begin
                    hit_next      = idx_reg[IDX_W-1:0];
                    hit_size_next = rd_size;
                    idx_next      = count_reg;  // first shift destination
                    state_next    = ST_SH_RD;
                end else begin
                    acc_next   = add_sum;
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_A_RD;
                end
            end

            // ---- open a slot after the split entry, top down ----
            ST_SH_RD: begin
                if (idx_reg <= hit_plus1) begin
                    state_next = ST_SPL_HI;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = IDX_W'(idx_reg - CNT_W'(1));
                    state_next = ST_SH_WR;
                end
            end

            ST_SH_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[IDX_W-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = idx_reg - CNT_W'(1);
                state_next = ST_SH_RD;
            end

            ST_SPL_HI: begin
                ram_we     = 1'b1;
                ram_waddr  = hit_plus1[IDX_W-1:0];
                ram_wdata  = {1'b0, hit_size_reg - 32'(HEADER_BYTES) - size_reg};
                state_next = ST_SPL_LO;
            end

            ST_SPL_LO: begin
                ram_we     = 1'b1;
                ram_waddr  = hit_reg;
                ram_wdata  = {1'b1, size_reg};
                count_next = count_reg + CNT_W'(1);
                state_next = ST_ADDR;
            end

            ST_APPEND: begin
                if (add_sum > {{(ACC_W-32){1'b0}}, bytes_reg}) begin
                    res_status_next = STATUS_NO_ROOM;
                    state_next      = ST_DONE;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = count_reg[IDX_W-1:0];
                    ram_wdata  = {1'b1, size_reg};
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_ADDR;
                end
            end

            ST_ADDR: begin
                res_addr_next   = add_sum[31:0];
                res_status_next = STATUS_OK;
                state_next      = ST_DONE;
            end

            // ---- free: search by payload address ----
            ST_F_RD: begin
                if (idx_reg == count_reg) begin
                    res_status_next = STATUS_UNKNOWN;
                    state_next      = ST_DONE;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_reg[IDX_W-1:0];
                    state_next = ST_F_EV;
                end
            end

            ST_F_EV: begin
                if (acc_reg[31:0] == rel_reg) begin
                    hit_next        = idx_reg[IDX_W-1:0];
                    idx_next        = '0;
                    wp_next         = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_M_RD;
                end else begin
                    acc_next   = add_sum;
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_F_RD;
                end
            end

            // ---- merge sweep: compact table, folding free runs ----
            ST_M_RD: begin
                if (idx_reg == count_reg) begin
                    state_next = ST_M_LAST;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_reg[IDX_W-1:0];
                    state_next = ST_M_EV;
                end
            end

            ST_M_EV: begin
                if (pend_valid_reg && !pend_used_reg && !merge_used) begin
                    pend_size_next = add_sum[31:0];
                end else begin
                    if (pend_valid_reg) begin
                        ram_we    = 1'b1;
                        ram_waddr = wp_reg[IDX_W-1:0];
                        ram_wdata = {pend_used_reg, pend_size_reg};
                        wp_next   = wp_reg + CNT_W'(1);
                    end
                    pend_valid_next = 1'b1;
                    pend_used_next  = merge_used;
                    pend_size_next  = rd_size;
                end
                idx_next   = idx_reg + CNT_W'(1);
                state_next = ST_M_RD;
            end

            ST_M_LAST: begin
                ram_we          = 1'b1;
                ram_waddr       = wp_reg[IDX_W-1:0];
                ram_wdata       = {pend_used_reg, pend_size_reg};
                count_next      = wp_reg + CNT_W'(1);
                res_status_next = STATUS_OK;
                state_next      = ST_DONE;
            end

            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, res_status_reg, res_addr_reg};
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // State update
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            base_reg    <= 32'd0;
            bytes_reg   <= 32'd16777216;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            bytes_reg   <= bytes_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        wp_reg         <= wp_next;
        hit_reg        <= hit_next;
        acc_reg        <= acc_next;
        size_reg       <= size_next;
        szh_reg        <= szh_next;
        hit_size_reg   <= hit_size_next;
        rel_reg        <= rel_next;
        pend_valid_reg <= pend_valid_next;
        pend_used_reg  <= pend_used_next;
        pend_size_reg  <= pend_size_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[hw/rtl/ffsa_checker.sv]
// ============================================================================
// ffsa_checker - port-level checks for the segment allocator
// Watches the stream ports only; attached to the top level by bind.
// ============================================================================
module ffsa_checker import ffsa_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // a stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item at a time: busy right after an item is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after accept");

    // any non-ok result carries a zero address
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33:32] != STATUS_OK) |-> m_tdata[31:0] == 32'd0)
        else $error("failed result with nonzero address");

    // reset leaves no result pending and the block ready
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset did not clear output");

endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
